FILE: hw/rtl/cte_pkg.sv
// shared types and constants of the capture timestamp extender
package cte_pkg;

  localparam int CHANNELS = 4;
  localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int TS_W     = 64;
  localparam int RAW_W    = 32;
  localparam int SRC_W    = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W    = 4;

  // input tdata layout, lowest bit first
  localparam int UPD_LSB  = 0;
  localparam int FLG_LSB  = 1;
  localparam int CAP_LSB  = 5;
  localparam int CNT_LSB  = CAP_LSB + 4 * RAW_W;
  localparam int IN_DATA_BITS = CNT_LSB + RAW_W;
  localparam int IN_TDATA_W   = ((IN_DATA_BITS + 7) / 8) * 8;

  localparam logic [RAW_W-1:0] MARK_32 = 32'h7fff_ffff;
  localparam logic [15:0]      MARK_16 = 16'h7fff;
  localparam logic [TS_W-1:0]  STEP_32 = 64'h0000_0001_0000_0000;
  localparam logic [TS_W-1:0]  STEP_16 = 64'h0000_0000_0001_0000;

  localparam logic [SRC_W-1:0] SRC_COUNTER = 3'd4;

  typedef enum logic {
    OP_IRQ  = 1'b0,
    OP_READ = 1'b1
  } cte_op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COUNTER_IS_32BIT    = 1'b0,
    REG_CHANNEL_ENABLE_MASK = 1'b1
  } cte_reg_t;

  typedef logic [TS_W-1:0] ts_t;

  // work handed from the lanes to the merge stage
  typedef struct packed {
    logic [CHANNELS-1:0] pend;
    logic                rd;
  } cte_batch_t;

  function automatic ts_t step_of(input logic is32);
    return is32 ? STEP_32 : STEP_16;
  endfunction

endpackage

FILE: hw/rtl/cte_lane.sv
// one lane: extends a raw capture value against the overflow base
module cte_lane (
  input  logic                   is32,
  input  logic                   update,
  input  cte_pkg::ts_t           base,
  input  logic [cte_pkg::RAW_W-1:0] raw,
  output cte_pkg::ts_t           ts
);
  import cte_pkg::*;

  logic [RAW_W-1:0] v;
  logic             below;
  ts_t              base_adj;

  always_comb begin
    v        = is32 ? raw : {{(RAW_W-16){1'b0}}, raw[15:0]};
    below    = is32 ? (raw < MARK_32) : (raw[15:0] < MARK_16);
    // capture taken just after the wrap: count the pending overflow now
    base_adj = (update && below) ? base + step_of(is32) : base;
    ts       = base_adj | {{(TS_W-RAW_W){1'b0}}, v};
  end

endmodule

FILE: hw/rtl/cte_merge.sv
// merge stage: holds one item's lane results and sends them out one beat a cycle unless out_tready stalls
module cte_merge (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  cte_pkg::cte_batch_t   ld_batch,
  input  cte_pkg::ts_t          ld_ts [cte_pkg::CHANNELS],
  output logic                  can_load,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [cte_pkg::TS_W-1:0]  out_tdata,
  output logic [cte_pkg::SRC_W-1:0] out_tuser,
  output logic                  out_tlast
);
  import cte_pkg::*;

  logic [CHANNELS-1:0] pend_r, pend_nxt;
  logic                rd_r, rd_nxt;
  ts_t                 ts_r [CHANNELS];
  logic                vld_r, vld_nxt;
  ts_t                 data_r, data_nxt;
  logic [SRC_W-1:0]    src_r, src_nxt;
  logic                last_r, last_nxt;

  logic [IDX_W-1:0]    sel;
  logic [CHANNELS-1:0] rest;
  logic                have, out_free, emit;

  always_comb begin
    sel = '0;
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      if (pend_r[i]) sel = IDX_W'(i);
    end
  end

  always_comb begin
    have     = |pend_r;
    out_free = !vld_r || out_tready;
    emit     = have && out_free;
    rest     = pend_r & ~(CHANNELS'(1) << sel);
    can_load = !have || (emit && (rest == '0));
  end

  always_comb begin
    pend_nxt = pend_r;
    rd_nxt   = rd_r;
    if (load) begin
      pend_nxt = ld_batch.pend;
      rd_nxt   = ld_batch.rd;
    end else if (emit) begin
      pend_nxt = rest;
    end

    vld_nxt  = vld_r;
    data_nxt = data_r;
    src_nxt  = src_r;
    last_nxt = last_r;
    if (emit) begin
      vld_nxt  = 1'b1;
      data_nxt = ts_r[sel];
      src_nxt  = rd_r ? SRC_COUNTER : SRC_W'(sel);
      last_nxt = (rest == '0);
    end else if (out_tready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      rd_r   <= 1'b0;
      vld_r  <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      rd_r   <= rd_nxt;
      vld_r  <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < CHANNELS; i++) ts_r[i] <= ld_ts[i];
    end
    data_r <= data_nxt;
    src_r  <= src_nxt;
    last_r <= last_nxt;
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = data_r;
  assign out_tuser  = src_r;
  assign out_tlast  = last_r;

endmodule

FILE: hw/rtl/capture_timestamp_extender_top.sv
// top level of the capture timestamp extender: config, overflow base, lanes and merge
//
//  channel   | dir | tdata (low bit up)                                  | tuser         | tlast
//  in_       | in  | update_flag, capture_flags, capture_value_0..3,     | operation     | -
//            |     | counter_value, 3 zero pad bits                      |               |
//  out_      | out | timestamp                                           | source        | last_of_run
//  cfg_      | in  | we / index / wdata: counter_is_32bit, channel_enable_mask
//
// an item is taken in a single handshake; all four lanes extend their values at once
// the merge stage sends one result beat per cycle unless out_tready stalls it, so an item
// with results holds the input until its last result is sent on; one with none does not hold it
// reset clears the overflow base, both config registers and the output valid
// out_tready low holds the output beat; the input stalls until the last result
// of the previous item moves into the output register
module capture_timestamp_extender_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // update_flag, capture_flags, capture_value_0..3, counter_value, pad
  input  logic [cte_pkg::IN_TDATA_W-1:0]     in_tdata,
  // operation
  input  logic [0:0]                         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // timestamp
  output logic [cte_pkg::TS_W-1:0]           out_tdata,
  // source
  output logic [cte_pkg::SRC_W-1:0]          out_tuser,
  output logic                               out_tlast,
  input  logic                               cfg_we,
  input  logic [cte_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cte_pkg::CFG_W-1:0]          cfg_wdata
);
  import cte_pkg::*;

  logic                is32_r;
  logic [CHANNELS-1:0] ena_r;
  ts_t                 base_r, base_nxt;

  logic                accept, is_read, update;
  logic [CHANNELS-1:0] flags;
  logic [RAW_W-1:0]    raw [CHANNELS];
  ts_t                 lane_ts [CHANNELS];
  cte_batch_t          batch;
  logic                can_load;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = can_load;
  assign is_read   = (cte_op_t'(in_tuser[0]) == OP_READ);
  assign update    = in_tdata[UPD_LSB];
  assign flags     = in_tdata[FLG_LSB +: CHANNELS];

  // lane 0 also serves the counter read
  always_comb begin
    for (int i = 0; i < CHANNELS; i++) raw[i] = in_tdata[CAP_LSB + i * RAW_W +: RAW_W];
    if (is_read) raw[0] = in_tdata[CNT_LSB +: RAW_W];
  end

  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    cte_lane u_lane (
      .is32   (is32_r),
      .update (update),
      .base   (base_r),
      .raw    (raw[g]),
      .ts     (lane_ts[g])
    );
  end

  always_comb begin
    batch.rd   = is_read;
    batch.pend = is_read ? CHANNELS'(1) : (flags & ena_r);
    base_nxt   = base_r;
    if (accept && !is_read && update) base_nxt = base_r + step_of(is32_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      is32_r <= 1'b0;
      ena_r  <= '0;
      base_r <= '0;
    end else begin
      base_r <= base_nxt;
      if (cfg_we) begin
        unique case (cte_reg_t'(cfg_index))
          REG_COUNTER_IS_32BIT:    is32_r <= cfg_wdata[0];
          REG_CHANNEL_ENABLE_MASK: ena_r  <= cfg_wdata[CHANNELS-1:0];
          default: ;
        endcase
      end
    end
  end

  cte_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (accept),
    .ld_batch   (batch),
    .ld_ts      (lane_ts),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

`ifndef SYNTH
  a_base_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (is_read || !update)) |=> (base_r == $past(base_r)))
    else $error("overflow base moved without an overflow interrupt");

  a_base_step: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !is_read && update) |=> (base_r == $past(base_r) + step_of($past(is32_r))))
    else $error("overflow base did not advance by one step");

  a_counter_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == SRC_COUNTER)) |-> out_tlast)
    else $error("counter read beat not marked last");

  a_src_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser <= SRC_COUNTER))
    else $error("source code out of range");
`endif

endmodule

FILE: tb/testbench.sv
// self-checking testbench for the capture timestamp extender: stream driver, monitor, predictor
module testbench;
  import cte_pkg::*;

  typedef struct {
    cte_op_t                      op;
    logic                         upd;
    logic [CHANNELS-1:0]          flags;
    logic [CHANNELS-1:0][RAW_W-1:0] cap;
    logic [RAW_W-1:0]             cnt;
  } svc_req_t;

  typedef struct {
    logic [TS_W-1:0]  ts;
    logic [SRC_W-1:0] src;
    logic             last;
  } stamp_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [0:0]            in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [TS_W-1:0]       out_tdata;
  logic [SRC_W-1:0]      out_tuser;
  logic                  out_tlast;
  logic                  cfg_we = 1'b0;
  cte_reg_t              cfg_index = REG_COUNTER_IS_32BIT;
  logic [CFG_W-1:0]      cfg_wdata = '0;

  // shadow of the block state
  logic [TS_W-1:0]     base_sh = '0;
  logic                is32_sh = 1'b0;
  logic [CHANNELS-1:0] mask_sh = '0;

  svc_req_t req_q[$];
  svc_req_t cur_req;
  stamp_t   stamps_due[$];
  int       tx_idle_pct = 0;
  int       rx_idle_pct = 0;
  int       bad_stamps = 0;

  capture_timestamp_extender_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [TS_W-1:0] extend_raw(input logic upd, input logic [RAW_W-1:0] raw);
    logic [TS_W-1:0] v;
    logic [TS_W-1:0] b;
    logic            below;
    v = is32_sh ? {32'd0, raw} : {48'd0, raw[15:0]};
    below = is32_sh ? (raw < MARK_32) : (raw[15:0] < MARK_16);
    b = base_sh;
    // the extra step applies to this timestamp only
    if (upd && below) b = b + (is32_sh ? STEP_32 : STEP_16);
    return b | v;
  endfunction

  task automatic predict_service(input svc_req_t r);
    stamp_t s;
    int     hits;
    int     k;
    hits = 0;
    k = 0;
    if (r.op == OP_READ) begin
      s.ts = extend_raw(r.upd, r.cnt);
      s.src = SRC_COUNTER;
      s.last = 1'b1;
      stamps_due.push_back(s);
    end else begin
      for (int n = 0; n < CHANNELS; n++) begin
        if (mask_sh[n] && r.flags[n]) hits++;
      end
      for (int n = 0; n < CHANNELS; n++) begin
        if (mask_sh[n] && r.flags[n]) begin
          s.ts = extend_raw(r.upd, r.cap[n]);
          s.src = SRC_W'(n);
          s.last = (k == hits - 1);
          stamps_due.push_back(s);
          k++;
        end
      end
      if (r.upd) base_sh = base_sh + (is32_sh ? STEP_32 : STEP_16);
    end
  endtask

  // driver: next item goes out once the current beat is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) predict_service(cur_req);
      if (req_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
        cur_req = req_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= {{(IN_TDATA_W - IN_DATA_BITS){1'b0}}, cur_req.cnt, cur_req.cap,
                     cur_req.flags, cur_req.upd};
        in_tuser <= cur_req.op;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_tready <= rst_n && ($urandom_range(99) >= rx_idle_pct);
  end

  // monitor
  always @(posedge clk) begin : watch
    stamp_t due;
    if (rst_n && out_tvalid && out_tready) begin
      if (stamps_due.size() == 0) begin
        bad_stamps++;
        if (bad_stamps <= 10)
          $display("unexpected beat: ts=%h src=%0d last=%b", out_tdata, out_tuser, out_tlast);
      end else begin
        due = stamps_due.pop_front();
        if (out_tdata !== due.ts || out_tuser !== due.src || out_tlast !== due.last) begin
          bad_stamps++;
          if (bad_stamps <= 10)
            $display("mismatch: expected ts=%h src=%0d last=%b, got ts=%h src=%0d last=%b",
                     due.ts, due.src, due.last, out_tdata, out_tuser, out_tlast);
        end
      end
    end
  end

  task automatic push_req(input cte_op_t op, input logic upd, input logic [3:0] flags,
                          input logic [31:0] c0, input logic [31:0] c1,
                          input logic [31:0] c2, input logic [31:0] c3,
                          input logic [31:0] cnt);
    svc_req_t r;
    r.op = op;
    r.upd = upd;
    r.flags = flags;
    r.cap[0] = c0;
    r.cap[1] = c1;
    r.cap[2] = c2;
    r.cap[3] = c3;
    r.cnt = cnt;
    req_q.push_back(r);
  endtask

  // raw values, many of them close to one of the half-range marks
  function automatic logic [RAW_W-1:0] rand_raw();
    case ($urandom_range(3))
      2:       return 32'h7fff_fffd + $urandom_range(4);
      3:       return {16'($urandom), 16'h7ffd + 16'($urandom_range(4))};
      default: return $urandom;
    endcase
  endfunction

  function automatic svc_req_t rand_req();
    svc_req_t r;
    r.op = ($urandom_range(99) < 25) ? OP_READ : OP_IRQ;
    r.upd = ($urandom_range(99) < 40);
    r.flags = 4'($urandom_range(15));
    for (int n = 0; n < CHANNELS; n++) r.cap[n] = rand_raw();
    r.cnt = rand_raw();
    return r;
  endfunction

  // hold the sender until every pending result is back, then let the block settle
  task automatic drain();
    while (req_q.size() > 0 || in_tvalid || stamps_due.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input cte_reg_t idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_COUNTER_IS_32BIT) is32_sh = val[0];
    else mask_sh = val;
  endtask

  task automatic configure(input logic is32, input logic [3:0] mask);
    drain();
    write_reg(REG_COUNTER_IS_32BIT, {3'b0, is32});
    write_reg(REG_CHANNEL_ENABLE_MASK, mask);
  endtask

  initial begin : stimulus
    logic       is32_list [6];
    logic [3:0] mask_list [6];
    is32_list = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
    mask_list = '{4'hf, 4'ha, 4'h0, 4'h5, 4'($urandom_range(15)), 4'hf};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    tx_idle_pct = 19;
    rx_idle_pct = 85;

    // 16-bit counter, all channels
    configure(1'b0, 4'hf);
    push_req(OP_IRQ, 1'b0, 4'hf, 32'h0, 32'hffff, 32'h7fff, 32'h7ffe, 32'h0);
    push_req(OP_IRQ, 1'b1, 4'hf, 32'h7ffe, 32'h7fff, 32'hffff_0000, 32'hffff_ffff, 32'h0);
    // nothing to report, base still moves
    push_req(OP_IRQ, 1'b1, 4'h0, $urandom, $urandom, $urandom, $urandom, $urandom);
    push_req(OP_READ, 1'b0, 4'hf, $urandom, $urandom, $urandom, $urandom, 32'habcd_1234);
    push_req(OP_READ, 1'b1, 4'h0, $urandom, $urandom, $urandom, $urandom, 32'h0000_7ffe);
    push_req(OP_READ, 1'b1, 4'hf, $urandom, $urandom, $urandom, $urandom, 32'hffff_ffff);
    push_req(OP_IRQ, 1'b0, 4'h1, $urandom, $urandom, $urandom, $urandom, $urandom);
    push_req(OP_IRQ, 1'b0, 4'h2, $urandom, $urandom, $urandom, $urandom, $urandom);
    push_req(OP_IRQ, 1'b1, 4'h4, $urandom, $urandom, $urandom, $urandom, $urandom);
    push_req(OP_IRQ, 1'b0, 4'h8, $urandom, $urandom, $urandom, $urandom, $urandom);

    // 32-bit counter
    configure(1'b1, 4'hf);
    push_req(OP_IRQ, 1'b1, 4'hf, 32'h7fff_fffe, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h0);
    push_req(OP_IRQ, 1'b0, 4'hf, 32'hffff_ffff, 32'h7fff_fffe, 32'h1, 32'h8000_0001, 32'h0);
    push_req(OP_READ, 1'b1, 4'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h7fff_fffe);
    push_req(OP_READ, 1'b0, 4'hf, 32'h0, 32'h0, 32'h0, 32'h0, 32'hffff_ffff);
    push_req(OP_IRQ, 1'b1, 4'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);

    // disabled channels ignore their flags
    configure(1'b1, 4'h5);
    push_req(OP_IRQ, 1'b1, 4'hf, $urandom, $urandom, $urandom, $urandom, $urandom);
    push_req(OP_IRQ, 1'b0, 4'ha, $urandom, $urandom, $urandom, $urandom, $urandom);

    configure(1'b0, 4'h0);
    push_req(OP_IRQ, 1'b1, 4'hf, $urandom, $urandom, $urandom, $urandom, $urandom);
    push_req(OP_READ, 1'b0, 4'h0, $urandom, $urandom, $urandom, $urandom, 32'h1234_5678);

    for (int p = 0; p < 6; p++) begin
      configure(is32_list[p], mask_list[p]);
      if (p >= 4) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else if (p >= 2) begin
        tx_idle_pct = 85;
        rx_idle_pct = 19;
      end
      repeat (15) req_q.push_back(rand_req());
    end

    drain();
    repeat (20) @(posedge clk);
    if (bad_stamps == 0 && stamps_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #(12 * 400000);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
